// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the slot binder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/asb_pkg.sv =====
// Package for the slot binder: sizes, constants and cell interface types.
package asb_pkg;

    localparam int NUM_SLOTS    = 16;
    localparam int REGION_WIDTH = 32;

    localparam int FIELD_W = 32;
    localparam int KEEP_W  = (REGION_WIDTH < FIELD_W) ? REGION_WIDTH : FIELD_W;
    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int CFG_W   = 5;
    localparam int AGE_W   = 8;
    localparam int OUT_IDX_W = 4;

    localparam logic [AGE_W-1:0] AGE_EMPTY = 8'd255;
    localparam logic [AGE_W-1:0] AGE_TOP   = 8'd254;
    localparam logic [AGE_W-1:0] AGE_FLOOR = 8'd0;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // search word passed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [AGE_W-1:0] age;
    } carry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              age_up;
        logic              rel_mode;
        logic [FIELD_W-1:0] key_id;
        logic [KEEP_W-1:0] offset;
        logic [KEEP_W-1:0] size;
        logic              dec_en;
        logic [AGE_W-1:0]  dec_level;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [AGE_W-1:0]  wr_age;
    } cell_ctl_t;

    // per-cell status back to the top level
    typedef struct packed {
        logic             fire;
        logic [AGE_W-1:0] age;
    } cell_stat_t;

endpackage

// ===== rtl/asb_cell.sv =====
// One binding slot: age and key storage, key compare and one search step.
`include "assert_macros.svh"

module asb_cell
    import asb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic             active,
    input  cell_ctl_t        ctl,
    input  carry_t           carry_in,
    output carry_t           carry_out,
    output cell_stat_t       stat
);

    logic [AGE_W-1:0]   age_reg, age_next;
    logic [FIELD_W-1:0] id_reg;
    logic [KEEP_W-1:0]  off_reg;
    logic [KEEP_W-1:0]  size_reg;
    carry_t             carry_reg, carry_next;
    logic               occupied;
    logic               id_match;
    logic               key_match;
    logic               fire;
    logic               wr_here;

    assign occupied  = active && (age_reg != AGE_EMPTY);
    assign id_match  = (id_reg == ctl.key_id);
    assign key_match = id_match && (off_reg == ctl.offset) && (size_reg == ctl.size);
    assign fire      = carry_in.valid && ctl.rel_mode && occupied && id_match;
    assign wr_here   = ctl.wr_en && (ctl.wr_idx == cell_idx);

    assign stat.fire = fire;
    assign stat.age  = age_reg;
    assign carry_out = carry_reg;

    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.valid && !ctl.rel_mode && active && !carry_in.hit)
        begin
            if (occupied && key_match)
            begin
                carry_next.hit = 1'b1;
                carry_next.idx = cell_idx;
            end
            else if (age_reg > carry_in.age)
            begin
                carry_next.age = age_reg;
                carry_next.idx = cell_idx;
            end
        end
    end

    always_comb
    begin
        age_next = age_reg;
        if (ctl.age_up && occupied && (age_reg < AGE_TOP))
            age_next = age_reg + 8'd1;
        else if (fire)
            age_next = AGE_EMPTY;
        else if (ctl.dec_en && occupied && (age_reg >= ctl.dec_level) &&
                 (age_reg != AGE_FLOOR))
            age_next = age_reg - 8'd1;
        else if (wr_here)
            age_next = ctl.wr_age;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg   <= AGE_EMPTY;
            carry_reg <= '0;
        end
        else
        begin
            age_reg   <= age_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            id_reg   <= ctl.key_id;
            off_reg  <= ctl.offset;
            size_reg <= ctl.size;
        end
    end

    `ASSERT_IMP(a_fire_is_rel, clk, rst_n, fire, ctl.rel_mode && carry_in.valid)
    `ASSERT_NXT(a_write_lands, clk, rst_n, wr_here && !ctl.age_up && !ctl.dec_en, age_reg == $past(ctl.wr_age))
    `ASSERT_IMP(a_idle_inactive, clk, rst_n, !active, !fire)

endmodule

// ===== rtl/aging_slot_binder.sv =====
// Slot binder top: a row of slot cells scanned in order by a traveling search word.
// Each item goes in order through accept and age, the search word crossing the cell
// row, and the slot write; no new item is accepted until it is through.
// A request raises done when its slot is written; a release gives none.
// busy is high from the accept edge until the result edge; the receiver cannot stall.
// Reset empties every slot at once and sets the slot count register cfg_reg to 16.
`include "assert_macros.svh"

module aging_slot_binder
    import asb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [FIELD_W-1:0]   key_id,
    input  logic [FIELD_W-1:0]   region_offset,
    input  logic [FIELD_W-1:0]   region_size,
    input  logic                 prioritize,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 done,
    output logic [OUT_IDX_W-1:0] slot_index,
    output logic                 was_bound
);

    logic                 busy_reg, busy_next;
    logic                 head_reg;
    logic                 done_reg, done_next;
    logic [OUT_IDX_W-1:0] slot_index_reg;
    logic                 was_bound_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic                 action_reg;
    logic                 prio_reg;
    logic [FIELD_W-1:0]   id_reg;
    logic [KEEP_W-1:0]    off_reg;
    logic [KEEP_W-1:0]    size_reg;

    logic                 accept;
    logic [CNT_W-1:0]     n_eff;
    logic [NUM_SLOTS-1:0] active_vec;
    logic [NUM_SLOTS-1:0] fire_vec;
    logic [AGE_W-1:0]     level;
    carry_t               chain [NUM_SLOTS+1];
    cell_stat_t           stat  [NUM_SLOTS];
    cell_ctl_t            ctl;
    carry_t               tail;

    assign accept = start && !busy_reg;
    assign tail   = chain[NUM_SLOTS];

    always_comb
    begin
        if (cfg_reg == '0)
            n_eff = CNT_W'(1);
        else if (int'(cfg_reg) > NUM_SLOTS)
            n_eff = CNT_W'(NUM_SLOTS);
        else
            n_eff = CNT_W'(cfg_reg);
    end

    always_comb
    begin
        level = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            fire_vec[i] = stat[i].fire;
            if (stat[i].fire)
                level = level | stat[i].age;
        end
    end

    always_comb
    begin
        ctl.age_up    = accept && (action == ACT_REQUEST) && prioritize;
        ctl.rel_mode  = (action_reg == ACT_RELEASE);
        ctl.key_id    = id_reg;
        ctl.offset    = off_reg;
        ctl.size      = size_reg;
        ctl.dec_en    = |fire_vec;
        ctl.dec_level = level;
        ctl.wr_en     = tail.valid && (action_reg == ACT_REQUEST);
        ctl.wr_idx    = tail.idx;
        ctl.wr_age    = prio_reg ? AGE_FLOOR : AGE_TOP;
    end

    assign chain[0] = '{valid: head_reg, hit: 1'b0, idx: '0, age: AGE_FLOOR};

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            assign active_vec[gi] = (gi < int'(n_eff));

            asb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IDX_W'(gi)),
                .active    (active_vec[gi]),
                .ctl       (ctl),
                .carry_in  (chain[gi]),
                .carry_out (chain[gi+1]),
                .stat      (stat[gi])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (accept)
            busy_next = 1'b1;
        else if (tail.valid)
        begin
            busy_next = 1'b0;
            done_next = (action_reg == ACT_REQUEST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            head_reg <= 1'b0;
            done_reg <= 1'b0;
            cfg_reg  <= CFG_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            head_reg <= accept;
            done_reg <= done_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            prio_reg   <= prioritize;
            id_reg     <= key_id;
            off_reg    <= region_offset[KEEP_W-1:0];
            size_reg   <= region_size[KEEP_W-1:0];
        end
        if (ctl.wr_en)
        begin
            slot_index_reg <= OUT_IDX_W'(tail.idx);
            was_bound_reg  <= tail.hit;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign slot_index = slot_index_reg;
    assign was_bound  = was_bound_reg;

    `ASSERT_IMP(a_one_fire, clk, rst_n, 1'b1, $onehot0(fire_vec))
    `ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `ASSERT_IMP(a_tail_busy, clk, rst_n, tail.valid, busy_reg)
    `ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy_reg && head_reg)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for aging_slot_binder: directed and random requests/releases.
module testbench;
    import asb_pkg::*;

    localparam int POOL_N = 6;
    localparam int DRAIN_CYCLES = NUM_SLOTS + 4;

    typedef struct {
        logic [OUT_IDX_W-1:0] idx;
        logic                 hit;
    } binding_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic [FIELD_W-1:0]   key_id;
    logic [FIELD_W-1:0]   region_offset;
    logic [FIELD_W-1:0]   region_size;
    logic                 prioritize;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 done;
    logic [OUT_IDX_W-1:0] slot_index;
    logic                 was_bound;

    // predicted table
    logic [AGE_W-1:0]   bnd_age  [NUM_SLOTS];
    logic [FIELD_W-1:0] bnd_id   [NUM_SLOTS];
    logic [KEEP_W-1:0]  bnd_off  [NUM_SLOTS];
    logic [KEEP_W-1:0]  bnd_size [NUM_SLOTS];
    logic [CFG_W-1:0]   slot_limit;

    binding_t expected_bindings[$];

    logic [FIELD_W-1:0] id_pool   [POOL_N];
    logic [FIELD_W-1:0] off_pool  [3];
    logic [FIELD_W-1:0] size_pool [3];

    int error_count = 0;
    int n_checked   = 0;
    int n_requests  = 0;
    int n_releases  = 0;
    int n_hits      = 0;
    int n_cfg       = 0;

    aging_slot_binder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key_id        (key_id),
        .region_offset (region_offset),
        .region_size   (region_size),
        .prioritize    (prioritize),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .slot_index    (slot_index),
        .was_bound     (was_bound)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("aging_slot_binder verification failed");
        $finish;
    end

    function automatic void predict_binding(input logic act, input logic [FIELD_W-1:0] id,
                                            input logic [FIELD_W-1:0] off,
                                            input logic [FIELD_W-1:0] sz, input logic prio);
        int n;
        int pick;
        bit found;
        logic [AGE_W-1:0] level;
        binding_t b;
        n = int'(slot_limit);
        if (n < 1) n = 1;
        if (n > NUM_SLOTS) n = NUM_SLOTS;
        if (act == ACT_RELEASE)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (bnd_age[i] != AGE_EMPTY && bnd_id[i] == id)
                begin
                    level = bnd_age[i];
                    for (int j = 0; j < n; j++)
                    begin
                        if (bnd_age[j] != AGE_EMPTY && bnd_age[j] >= level &&
                            bnd_age[j] != AGE_FLOOR)
                            bnd_age[j] = bnd_age[j] - 1'b1;
                    end
                    bnd_age[i]  = AGE_EMPTY;
                    bnd_id[i]   = '0;
                    bnd_off[i]  = '0;
                    bnd_size[i] = '0;
                end
            end
        end
        else
        begin
            if (prio)
            begin
                for (int i = 0; i < n; i++)
                    if (bnd_age[i] != AGE_EMPTY && bnd_age[i] < AGE_TOP)
                        bnd_age[i] = bnd_age[i] + 1'b1;
            end
            found = 1'b0;
            pick = 0;
            for (int i = 0; i < n; i++)
            begin
                if (!found && bnd_age[i] != AGE_EMPTY && bnd_id[i] == id &&
                    bnd_off[i] == off[KEEP_W-1:0] && bnd_size[i] == sz[KEEP_W-1:0])
                begin
                    pick = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                pick = 0;
                for (int i = 1; i < n; i++)
                    if (bnd_age[i] > bnd_age[pick]) pick = i;
            end
            bnd_age[pick]  = prio ? AGE_FLOOR : AGE_TOP;
            bnd_id[pick]   = id;
            bnd_off[pick]  = off[KEEP_W-1:0];
            bnd_size[pick] = sz[KEEP_W-1:0];
            b.idx = OUT_IDX_W'(pick);
            b.hit = found;
            if (found) n_hits++;
            expected_bindings.push_back(b);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_binding
        binding_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_bindings.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual slot %0d bound %0b",
                         $time, slot_index, was_bound);
                error_count++;
            end
            else
            begin
                want = expected_bindings.pop_front();
                if (slot_index !== want.idx)
                begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.idx, slot_index);
                    error_count++;
                end
                if (was_bound !== want.hit)
                begin
                    $display("%0t: was_bound expected %0b actual %0b",
                             $time, want.hit, was_bound);
                    error_count++;
                end
                n_checked++;
            end
        end
    end

    task automatic send_word(input logic act, input logic [FIELD_W-1:0] id,
                             input logic [FIELD_W-1:0] off, input logic [FIELD_W-1:0] sz,
                             input logic prio);
        start         <= 1'b1;
        action        <= act;
        key_id        <= id;
        region_offset <= off;
        region_size   <= sz;
        prioritize    <= prio;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_binding(act, id, off, sz, prio);
        if (act == ACT_RELEASE) n_releases++;
        else n_requests++;
    endtask

    task automatic idle_maybe();
        if ($urandom_range(99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    // wait until all bindings are back and the block has settled
    task automatic drain_bindings();
        start <= 1'b0;
        @(posedge clk);
        while (expected_bindings.size() != 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        drain_bindings();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        slot_limit = value;
        n_cfg++;
    endtask

    task automatic refresh_pools();
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++) id_pool[i] = $urandom;
        off_pool[0]  = '0;
        off_pool[1]  = '1;
        off_pool[2]  = $urandom;
        size_pool[0] = '0;
        size_pool[1] = '1;
        size_pool[2] = $urandom;
    endtask

    task automatic test_requests();
        send_word(ACT_REQUEST, 32'hA5A5_0001, 32'h10, 32'h20, 1'b1);
        send_word(ACT_REQUEST, 32'h5A5A_0002, 32'h0, 32'h0, 1'b1);
        send_word(ACT_REQUEST, 32'hA5A5_0001, 32'h10, 32'h20, 1'b1);
        // all-zero key must not hit empty slots holding zero keys
        send_word(ACT_REQUEST, 32'h0, 32'h0, 32'h0, 1'b0);
        send_word(ACT_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // oldest entry already at top: aging saturates
        send_word(ACT_REQUEST, 32'h0, 32'h0, 32'h0, 1'b1);
        send_word(ACT_REQUEST, 32'hA5A5_0001, 32'h11, 32'h20, 1'b1);
        send_word(ACT_REQUEST, 32'hA5A5_0001, 32'h10, 32'h21, 1'b0);
    endtask

    task automatic test_releases();
        send_word(ACT_RELEASE, 32'hA5A5_0001, 32'h0, 32'h0, 1'b0);
        send_word(ACT_RELEASE, 32'h1234_5678, 32'h0, 32'h0, 1'b1);
        send_word(ACT_RELEASE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(ACT_REQUEST, 32'hA5A5_0001, 32'h10, 32'h20, 1'b0);
        send_word(ACT_RELEASE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
        send_word(ACT_REQUEST, 32'h5A5A_0002, 32'h0, 32'h0, 1'b1);
    endtask

    task automatic test_slot_limits();
        write_slot_count(5'd0);
        send_word(ACT_REQUEST, 32'hC0DE_0003, 32'h4, 32'h8, 1'b1);
        send_word(ACT_REQUEST, 32'hC0DE_0004, 32'h4, 32'h8, 1'b1);
        send_word(ACT_RELEASE, 32'hC0DE_0003, 32'h0, 32'h0, 1'b0);
        write_slot_count(5'd31);
        send_word(ACT_REQUEST, 32'hC0DE_0005, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(ACT_REQUEST, 32'h0, 32'h0, 32'h0, 1'b1);
    endtask

    // two slots: one key is hammered while the other ages into saturation
    task automatic test_age_saturation();
        logic [FIELD_W-1:0] cold_id;
        logic [FIELD_W-1:0] hot_id;
        cold_id = $urandom;
        hot_id  = cold_id ^ 32'h8000_0001;
        write_slot_count(5'd2);
        send_word(ACT_REQUEST, cold_id, 32'h0, 32'h0, 1'b1);
        for (int k = 0; k < 300; k++)
        begin
            send_word(ACT_REQUEST, hot_id, 32'h0, 32'h0, 1'b1);
            idle_maybe();
        end
        send_word(ACT_REQUEST, cold_id, 32'h0, 32'h0, 1'b1);
        send_word(ACT_RELEASE, hot_id, 32'h0, 32'h0, 1'b0);
        send_word(ACT_RELEASE, cold_id, 32'h0, 32'h0, 1'b0);
    endtask

    task automatic run_random_phase(input int count, input bit steady);
        int r;
        logic act;
        logic prio;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] off;
        logic [FIELD_W-1:0] sz;
        refresh_pools();
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            act = (r < 20) ? ACT_RELEASE : ACT_REQUEST;
            if (r >= 90)
            begin
                id  = $urandom;
                off = $urandom;
                sz  = $urandom;
            end
            else
            begin
                id  = id_pool[$urandom_range(POOL_N - 1)];
                off = off_pool[$urandom_range(2)];
                sz  = size_pool[$urandom_range(2)];
            end
            prio = ($urandom_range(99) < 60);
            send_word(act, id, off, sz, prio);
            if (k == count / 2 && !steady) drain_bindings();
            else if (!steady) idle_maybe();
        end
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] settings [8];
        settings = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd3, 5'd16, 5'd0};
        settings[7] = CFG_W'($urandom_range(1, 31));
        for (int p = 0; p < 8; p++)
        begin
            write_slot_count(settings[p]);
            run_random_phase(190, p == 2);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ACT_REQUEST;
        key_id        = '0;
        region_offset = '0;
        region_size   = '0;
        prioritize    = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            bnd_age[i]  = AGE_EMPTY;
            bnd_id[i]   = '0;
            bnd_off[i]  = '0;
            bnd_size[i] = '0;
        end
        slot_limit = CFG_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_requests();
        test_releases();
        test_slot_limits();
        test_age_saturation();
        test_random();

        drain_bindings();
        $display("Ran %0d requests (%0d hits) and %0d releases across %0d slot-count writes",
                 n_requests, n_hits, n_releases, n_cfg);
        $display("Checked %0d result words, %0d mismatches", n_checked, error_count);
        if (error_count == 0)
            $display("aging_slot_binder verification clean");
        else
            $display("aging_slot_binder verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/asb_pkg.sv
rtl/asb_cell.sv
rtl/aging_slot_binder.sv
verif/testbench.sv
